[rtl/sorted_priority_queue_assert.svh]
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// clocked check, idle while reset is held
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted priority queue check failed");

// clocked check that also holds during reset
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sorted priority queue check failed");

`else

`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

    // fixed field widths
    localparam int CAP_W  = 10;
    localparam int RNG_W  = 15;
    localparam int KEY_W  = CAP_W + RNG_W;
    localparam int TEXT_W = 64;
    localparam int SPD_W  = 11;
    localparam int STAT_W = 2;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_POP_OUT = 4'b0010,
        ST_WALK    = 4'b0100,
        ST_PUT     = 4'b1000
    } t_state;

endpackage

`default_nettype wire

[rtl/sorted_priority_queue.sv]
// pop: an accepted item moves to ST_POP_OUT, which takes the head record; the result strobe is registered after it
// push: stored entries are walked from the tail, each shifted back one slot, until one outranks the new
//   record or the front is reached; the walk is set by the single compare unit and one ram read port
// pop on an empty queue or push on a full one: result strobe in the cycle after acceptance
// busy drops with the result strobe; o_done is high one cycle and cannot be stalled
// synchronous active-low reset empties the queue; stored records are not cleared
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TEXT_BYTES  = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_action,
    input  wire logic [spq_pkg::CAP_W-1:0]          i_seat_capacity,
    input  wire logic [spq_pkg::RNG_W-1:0]          i_range_km,
    input  wire logic [spq_pkg::TEXT_W-1:0]         i_maker_text,
    input  wire logic [spq_pkg::TEXT_W-1:0]         i_model_text,
    input  wire logic [spq_pkg::SPD_W-1:0]          i_top_speed,
    output logic                                    o_done,
    output logic [spq_pkg::STAT_W-1:0]              o_status,
    output logic [spq_pkg::CAP_W-1:0]               o_out_capacity,
    output logic [spq_pkg::RNG_W-1:0]               o_out_range,
    output logic [spq_pkg::TEXT_W-1:0]              o_out_maker,
    output logic [spq_pkg::TEXT_W-1:0]              o_out_model,
    output logic [spq_pkg::SPD_W-1:0]               o_out_speed,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      o_fill_count
);

    import spq_pkg::*;

    `include "sorted_priority_queue_assert.svh"

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = 8 * TEXT_BYTES;

    // ring position of logical slot off, head + off wrapped once
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [PW-1:0] off);
        logic [PW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (PW + 1)'(QUEUE_DEPTH)) begin
            s = s - (PW + 1)'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    // record storage, one ring in four arrays sharing an address
    logic [KEY_W-1:0] key_mem   [QUEUE_DEPTH];
    logic [TW-1:0]    maker_mem [QUEUE_DEPTH];
    logic [TW-1:0]    model_mem [QUEUE_DEPTH];
    logic [SPD_W-1:0] speed_mem [QUEUE_DEPTH];

    t_state           r_state, n_state;
    logic [PW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    r_idx, n_idx;

    logic [KEY_W-1:0] r_new_key, n_new_key;
    logic [TW-1:0]    r_new_maker, n_new_maker;
    logic [TW-1:0]    r_new_model, n_new_model;
    logic [SPD_W-1:0] r_new_speed, n_new_speed;

    logic [KEY_W-1:0] r_rd_key;
    logic [TW-1:0]    r_rd_maker;
    logic [TW-1:0]    r_rd_model;
    logic [SPD_W-1:0] r_rd_speed;

    logic             r_done, n_done;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [TW-1:0]    r_out_maker, n_out_maker;
    logic [TW-1:0]    r_out_model, n_out_model;
    logic [SPD_W-1:0] r_out_speed, n_out_speed;
    logic [CW-1:0]    r_out_fill, n_out_fill;

    logic [PW-1:0]    rd_addr;
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [TW-1:0]    wr_maker;
    logic [TW-1:0]    wr_model;
    logic [SPD_W-1:0] wr_speed;

    logic             outranks;
    logic [CW-1:0]    last_slot;

    logic             pop_on_empty;
    logic             pop_on_data;

    // shared compare unit: stored entry against the record being pushed
    always_comb begin
        if (r_rd_key != r_new_key) begin
            outranks = (r_rd_key > r_new_key);
        end else if (r_rd_maker != r_new_maker) begin
            outranks = (r_rd_maker < r_new_maker);
        end else begin
            outranks = (r_rd_model < r_new_model);
        end
    end

    assign last_slot = r_count - CW'(1);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_new_key    = r_new_key;
        n_new_maker  = r_new_maker;
        n_new_model  = r_new_model;
        n_new_speed  = r_new_speed;
        n_done       = 1'b0;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_maker  = r_out_maker;
        n_out_model  = r_out_model;
        n_out_speed  = r_out_speed;
        n_out_fill   = r_out_fill;
        rd_addr      = r_head;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        wr_key       = r_new_key;
        wr_maker     = r_new_maker;
        wr_model     = r_new_model;
        wr_speed     = r_new_speed;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_new_key   = {i_seat_capacity, i_range_km};
                    n_new_maker = i_maker_text[TW-1:0];
                    n_new_model = i_model_text[TW-1:0];
                    n_new_speed = i_top_speed;
                    if (i_action == ACT_POP) begin
                        if (r_count == '0) begin
                            n_done       = 1'b1;
                            n_out_status = STAT_EMPTY;
                            n_out_key    = '0;
                            n_out_maker  = '0;
                            n_out_model  = '0;
                            n_out_speed  = '0;
                            n_out_fill   = r_count;
                        end else begin
                            rd_addr = r_head;
                            n_state = ST_POP_OUT;
                        end
                    end else begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_done       = 1'b1;
                            n_out_status = STAT_FULL;
                            n_out_key    = '0;
                            n_out_maker  = '0;
                            n_out_model  = '0;
                            n_out_speed  = '0;
                            n_out_fill   = r_count;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = ST_PUT;
                        end else begin
                            // start the walk at the tail entry
                            n_idx   = last_slot[PW-1:0];
                            rd_addr = phys(r_head, last_slot[PW-1:0]);
                            n_state = ST_WALK;
                        end
                    end
                end
            end

            ST_POP_OUT: begin
                n_done       = 1'b1;
                n_out_status = STAT_OK;
                n_out_key    = r_rd_key;
                n_out_maker  = r_rd_maker;
                n_out_model  = r_rd_model;
                n_out_speed  = r_rd_speed;
                n_head       = phys(r_head, PW'(1));
                n_count      = r_count - CW'(1);
                n_out_fill   = r_count - CW'(1);
                n_state      = ST_IDLE;
            end

            ST_WALK: begin
                // entry r_idx moves back one slot or the new record lands behind it
                wr_en   = 1'b1;
                wr_addr = phys(r_head, r_idx + PW'(1));
                if (outranks) begin
                    n_done       = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_key    = '0;
                    n_out_maker  = '0;
                    n_out_model  = '0;
                    n_out_speed  = '0;
                    n_count      = r_count + CW'(1);
                    n_out_fill   = r_count + CW'(1);
                    n_state      = ST_IDLE;
                end else begin
                    wr_key   = r_rd_key;
                    wr_maker = r_rd_maker;
                    wr_model = r_rd_model;
                    wr_speed = r_rd_speed;
                    if (r_idx == '0) begin
                        n_state = ST_PUT;
                    end else begin
                        n_idx   = r_idx - PW'(1);
                        rd_addr = phys(r_head, r_idx - PW'(1));
                    end
                end
            end

            ST_PUT: begin
                // new record goes to the front slot
                wr_en        = 1'b1;
                wr_addr      = r_head;
                n_done       = 1'b1;
                n_out_status = STAT_OK;
                n_out_key    = '0;
                n_out_maker  = '0;
                n_out_model  = '0;
                n_out_speed  = '0;
                n_count      = r_count + CW'(1);
                n_out_fill   = r_count + CW'(1);
                n_state      = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // record ram, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            maker_mem[wr_addr] <= wr_maker;
            model_mem[wr_addr] <= wr_model;
            speed_mem[wr_addr] <= wr_speed;
        end
        r_rd_key   <= key_mem[rd_addr];
        r_rd_maker <= maker_mem[rd_addr];
        r_rd_model <= model_mem[rd_addr];
        r_rd_speed <= speed_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_done  <= n_done;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_new_key    <= n_new_key;
        r_new_maker  <= n_new_maker;
        r_new_model  <= n_new_model;
        r_new_speed  <= n_new_speed;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_maker  <= n_out_maker;
        r_out_model  <= n_out_model;
        r_out_speed  <= n_out_speed;
        r_out_fill   <= n_out_fill;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_out_status;
    assign o_out_capacity = r_out_key[KEY_W-1:RNG_W];
    assign o_out_range    = r_out_key[RNG_W-1:0];
    assign o_out_maker    = TEXT_W'(r_out_maker);
    assign o_out_model    = TEXT_W'(r_out_model);
    assign o_out_speed    = r_out_speed;
    assign o_fill_count   = r_out_fill;

    // accepted pops, split by whether a record is stored
    assign pop_on_empty = start && !busy && (i_action == ACT_POP) && (r_count == '0);
    assign pop_on_data  = start && !busy && (i_action == ACT_POP) && (r_count != '0);

    // checks
    `SPQ_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_done)
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH))
    `SPQ_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy)
    `SPQ_ASSERT(a_walk_in_range, i_clk, i_rst_n, (r_state == ST_WALK) |-> (CW'(r_idx) < r_count))
    `SPQ_ASSERT(a_pop_empty, i_clk, i_rst_n, pop_on_empty |=> (o_done && o_status == STAT_EMPTY))
    `SPQ_ASSERT(a_pop_ok, i_clk, i_rst_n, pop_on_data |-> ##2 (o_done && o_status == STAT_OK))

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TEXT_BYTES   = 8;
    localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam logic [TEXT_W-1:0] TEXT_MASK = {TEXT_W{1'b1}} >> (TEXT_W - 8 * TEXT_BYTES);

    // a few packed names, first character in the top byte
    localparam logic [TEXT_W-1:0] TXT_AERO  = 64'h4145_524F_0000_0000;
    localparam logic [TEXT_W-1:0] TXT_AEROX = 64'h4145_524F_5800_0000;
    localparam logic [TEXT_W-1:0] TXT_ZEPH  = 64'h5A45_5048_0000_0000;
    localparam logic [TEXT_W-1:0] TXT_M0    = 64'h4D30_0000_0000_0000;
    localparam logic [TEXT_W-1:0] TXT_M1    = 64'h4D31_0000_0000_0000;

    typedef struct packed {
        logic [CAP_W-1:0]  cap;
        logic [RNG_W-1:0]  rng;
        logic [TEXT_W-1:0] maker;
        logic [TEXT_W-1:0] model;
        logic [SPD_W-1:0]  speed;
    } t_plane_rec;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_plane_rec        rec;
        logic [FILL_W-1:0] fill;
    } t_reply;

    // mirror of the queue contents plus the replies still to come
    class queue_tracker;
        t_plane_rec  slots[QUEUE_DEPTH];
        int unsigned held;
        t_reply      awaited_replies[$];
        int unsigned err_count;
        int unsigned reply_index;

        function new();
            held        = 0;
            err_count   = 0;
            reply_index = 0;
        endfunction

        // rank: capacity high, range high, maker low, model low
        function bit outranks(t_plane_rec a, t_plane_rec b);
            if (a.cap != b.cap) return a.cap > b.cap;
            if (a.rng != b.rng) return a.rng > b.rng;
            if (a.maker != b.maker) return a.maker < b.maker;
            return a.model < b.model;
        endfunction

        // apply one accepted item to the mirror and queue its reply
        function void note_item(logic act, t_plane_rec r);
            t_reply      want;
            int unsigned pos;
            want = '0;
            if (act == ACT_PUSH) begin
                if (held >= QUEUE_DEPTH) begin
                    want.status = STAT_FULL;
                end else begin
                    r.maker = r.maker & TEXT_MASK;
                    r.model = r.model & TEXT_MASK;
                    pos = 0;
                    while (pos < held && outranks(slots[pos], r)) pos++;
                    for (int i = held; i > pos; i--) slots[i] = slots[i - 1];
                    slots[pos] = r;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    want.status = STAT_EMPTY;
                end else begin
                    want.rec = slots[0];
                    for (int i = 1; i < held; i++) slots[i - 1] = slots[i];
                    held--;
                end
            end
            want.fill = FILL_W'(held);
            awaited_replies = {awaited_replies, want};
        endfunction

        function int unsigned outstanding();
            return awaited_replies.size();
        endfunction

        task report_mismatch(string what, logic [TEXT_W-1:0] got, logic [TEXT_W-1:0] want);
            $display("%0t: reply %0d %s mismatch: got %0h, expected %0h",
                     $time, reply_index, what, got, want);
            err_count++;
        endtask

        // compare one strobed reply with the oldest one outstanding
        task check_result(logic [STAT_W-1:0] status, t_plane_rec got, logic [FILL_W-1:0] fill);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected reply", TEXT_W'(status), '0);
            end else begin
                want = awaited_replies[0];
                awaited_replies.delete(0);
                if (status !== want.status)
                    report_mismatch("status", TEXT_W'(status), TEXT_W'(want.status));
                if (got.cap !== want.rec.cap)
                    report_mismatch("capacity", TEXT_W'(got.cap), TEXT_W'(want.rec.cap));
                if (got.rng !== want.rec.rng)
                    report_mismatch("range", TEXT_W'(got.rng), TEXT_W'(want.rec.rng));
                if (got.maker !== want.rec.maker)
                    report_mismatch("maker", got.maker, want.rec.maker);
                if (got.model !== want.rec.model)
                    report_mismatch("model", got.model, want.rec.model);
                if (got.speed !== want.rec.speed)
                    report_mismatch("speed", TEXT_W'(got.speed), TEXT_W'(want.rec.speed));
                if (fill !== want.fill)
                    report_mismatch("fill count", TEXT_W'(fill), TEXT_W'(want.fill));
            end
            reply_index++;
        endtask
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              start           = 1'b0;
    logic              i_action        = ACT_PUSH;
    logic [CAP_W-1:0]  i_seat_capacity = '0;
    logic [RNG_W-1:0]  i_range_km      = '0;
    logic [TEXT_W-1:0] i_maker_text    = '0;
    logic [TEXT_W-1:0] i_model_text    = '0;
    logic [SPD_W-1:0]  i_top_speed     = '0;
    logic              busy;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [CAP_W-1:0]  o_out_capacity;
    logic [RNG_W-1:0]  o_out_range;
    logic [TEXT_W-1:0] o_out_maker;
    logic [TEXT_W-1:0] o_out_model;
    logic [SPD_W-1:0]  o_out_speed;
    logic [FILL_W-1:0] o_fill_count;

    queue_tracker sb = new();
    int unsigned  burst_left = 0;

    sorted_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TEXT_BYTES (TEXT_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_seat_capacity(i_seat_capacity),
        .i_range_km     (i_range_km),
        .i_maker_text   (i_maker_text),
        .i_model_text   (i_model_text),
        .i_top_speed    (i_top_speed),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_out_capacity (o_out_capacity),
        .o_out_range    (o_out_range),
        .o_out_maker    (o_out_maker),
        .o_out_model    (o_out_model),
        .o_out_speed    (o_out_speed),
        .o_fill_count   (o_fill_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status,
                            {o_out_capacity, o_out_range, o_out_maker, o_out_model, o_out_speed},
                            o_fill_count);
    end

    function automatic t_plane_rec make_plane(logic [CAP_W-1:0] cap, logic [RNG_W-1:0] rng,
                                              logic [TEXT_W-1:0] maker,
                                              logic [TEXT_W-1:0] model,
                                              logic [SPD_W-1:0] speed);
        t_plane_rec r;
        r.cap   = cap;
        r.rng   = rng;
        r.maker = maker;
        r.model = model;
        r.speed = speed;
        return r;
    endfunction

    // mostly a small pool so that ties reach the lower keys
    function automatic logic [TEXT_W-1:0] pick_text();
        case ($urandom_range(0, 7))
            0:       return TXT_AERO;
            1:       return TXT_AEROX;
            2:       return TXT_ZEPH;
            3:       return TXT_M0;
            4:       return '0;
            5:       return {TEXT_W{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_plane_rec random_plane();
        t_plane_rec r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r.cap = CAP_W'($urandom_range(0, 3));
            5:             r.cap = {CAP_W{1'b1}};
            6:             r.cap = '0;
            default:       r.cap = CAP_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r.rng = RNG_W'($urandom_range(0, 2) * 100);
            5:             r.rng = {RNG_W{1'b1}};
            default:       r.rng = RNG_W'($urandom);
        endcase
        r.maker = pick_text();
        r.model = pick_text();
        r.speed = SPD_W'($urandom);
        return r;
    endfunction

    // present one item from a falling edge and hold it until accepted
    task automatic drive_item(input logic act, input t_plane_rec r);
        start           = 1'b1;
        i_action        = act;
        i_seat_capacity = r.cap;
        i_range_km      = r.rng;
        i_maker_text    = r.maker;
        i_model_text    = r.model;
        i_top_speed     = r.speed;
        do @(posedge i_clk); while (busy);
        sb.note_item(act, r);
        @(negedge i_clk);
    endtask

    // send an item, then between bursts idle for a random gap, which may be none
    task automatic issue(input logic act, input t_plane_rec r);
        int unsigned gap;
        drive_item(act, r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // stimulus
    initial begin
        int unsigned push_pct;
        int unsigned phase_left;
        logic        act;

        push_pct   = 50;
        phase_left = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, key extremes, ties at each rank level, fill to full, push on full, pops
        issue(ACT_POP, random_plane());
        issue(ACT_PUSH, make_plane('0, '0, '0, '0, '0));
        issue(ACT_PUSH, make_plane('1, '1, '1, '1, '1));
        issue(ACT_PUSH, make_plane(10'd5, 15'd100, TXT_AERO, TXT_M1, 11'd1));
        issue(ACT_PUSH, make_plane(10'd5, 15'd100, TXT_AERO, TXT_M1, 11'd2));
        issue(ACT_PUSH, make_plane(10'd5, 15'd100, TXT_AERO, TXT_M0, 11'd3));
        issue(ACT_PUSH, make_plane(10'd5, 15'd100, TXT_AEROX, TXT_M1, 11'd4));
        issue(ACT_PUSH, make_plane(10'd5, 15'd101, TXT_ZEPH, TXT_M1, 11'd5));
        issue(ACT_PUSH, make_plane(10'd6, 15'd0, TXT_ZEPH, TXT_M1, 11'd6));
        issue(ACT_PUSH, make_plane('1, '1, '1, '1, 11'd7));
        repeat (QUEUE_DEPTH - 9) issue(ACT_PUSH, random_plane());
        issue(ACT_PUSH, random_plane());
        repeat (3) issue(ACT_POP, random_plane());

        // random: phases leaning toward push or pop sweep the fill level
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            phase_left--;
            act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
            issue(act, random_plane());
        end
        start = 1'b0;

        // drain
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // about 720 items; the timeout is many times their worst-case run time
    initial begin
        #2_000_000;
        $display("timeout waiting for the queue");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/spq_pkg.sv
rtl/sorted_priority_queue.sv
sim/testbench.sv
